[design/svg_pkg.sv]
// ----------------------------------------------------------------------------
// svg_pkg
// Shared types, constants and rounding helper for the sphere vertex generator.
// ----------------------------------------------------------------------------
`default_nettype none

package svg_pkg;

   localparam int MAX_VERTICES_DEF   = 65535;
   localparam int UNIT_FRAC_BITS_DEF = 14;

   // CORDIC datapath: signed Q30 with headroom
   localparam int CORDIC_W     = 34;
   localparam int CORDIC_STEPS = 30;

   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic [30:0]                HALF_PI_Q30 = 31'd1686629713;
   localparam logic signed [31:0]         Q30_ONE     = 32'sd1073741824;
   localparam logic signed [31:0]         POS_LIMIT   = 32'sd65535;

   localparam logic signed [CORDIC_W-1:0] ATAN_Q30 [CORDIC_STEPS] = '{
      34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158, 34'sd67021686,
      34'sd33543515,  34'sd16775850,  34'sd8388437,   34'sd4194282,   34'sd2097149,
      34'sd1048575,   34'sd524287,    34'sd262143,    34'sd131071,    34'sd65535,
      34'sd32767,     34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
      34'sd1023,      34'sd511,       34'sd255,       34'sd127,       34'sd63,
      34'sd31,        34'sd15,        34'sd7,         34'sd3,         34'sd1
   };

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_EMPTY    = 2'd1,
      STAT_TOO_MANY = 2'd2,
      STAT_RANGE    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      KIND_RING   = 2'd0,
      KIND_TOP    = 2'd1,
      KIND_BOTTOM = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CSR_RADIUS   = 2'd0,
      CSR_SLICES   = 2'd1,
      CSR_STACKS   = 2'd2,
      CSR_INVERTED = 2'd3
   } csr_addr_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] vnum;
      kind_type    kind;
   } meta_type;

   // round to nearest, ties away from zero, then shift down by k
   function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                      input int k);
      logic [63:0] mag;
      logic [63:0] r;
      mag = v[63] ? 64'(-v) : 64'(v);
      r   = (mag + (64'd1 << (k - 1))) >> k;
      return v[63] ? -$signed(r) : $signed(r);
   endfunction

endpackage

`default_nettype wire

[design/sphere_vertex_generator_top.sv]
// ----------------------------------------------------------------------------
// sphere_vertex_generator_top
// Pipelined UV sphere vertex generator: position, normal and list index.
// ----------------------------------------------------------------------------
//  channel   ports                                 handshake
//  request   start, busy, req_stack_index/slice    taken when start & !busy
//  response  rsp_valid, rsp_pos_*, rsp_norm_*, ... one-cycle strobe, no stall
//  csr       csr_valid, csr_ready, csr_index/data  written when valid & ready
//
// One vertex enters every cycle; busy stays low. A taken request passes through
// the pipeline on its way to the response ports: eight phase-divider stages
// (four quotient bits each), one angle stage, fifteen CORDIC stages (two
// rotations each) and four product, rounding and output stages. Reset clears
// the stage valid bits and loads the register defaults. The receiver cannot
// stall, so stages advance every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_vertex_generator_top import svg_pkg::*; #(
   parameter int MAX_VERTICES   = MAX_VERTICES_DEF,
   parameter int UNIT_FRAC_BITS = UNIT_FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [9:0]         req_stack_index,
   input  logic [9:0]         req_slice_index,
   output logic               rsp_valid,
   output logic signed [16:0] rsp_pos_x,
   output logic signed [16:0] rsp_pos_y,
   output logic signed [16:0] rsp_pos_z,
   output logic signed [15:0] rsp_norm_x,
   output logic signed [15:0] rsp_norm_y,
   output logic signed [15:0] rsp_norm_z,
   output logic [15:0]        rsp_vertex_number,
   output logic [1:0]         rsp_status,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data
);

   localparam int DIV_BITS  = 32;
   localparam int DIV_PER   = 4;
   localparam int DIV_STG   = DIV_BITS / DIV_PER;
   localparam int CORD_PER  = 2;
   localparam int CORD_STG  = CORDIC_STEPS / CORD_PER;
   localparam int ST_Z      = DIV_STG + 1;
   localparam int ST_MUL    = ST_Z + CORD_STG + 1;
   localparam int ST_RND    = ST_MUL + 1;
   localparam int ST_RAD    = ST_RND + 1;
   localparam int NSH       = 30 - UNIT_FRAC_BITS;
   localparam int NV_W      = 21;
   localparam int CW        = CORDIC_W;
   localparam logic signed [31:0] NORM_LIM = 32'sd1 <<< UNIT_FRAC_BITS;

   // ---------------------------------------------------------------- registers
   logic [15:0] radius_ff;
   logic [9:0]  slices_ff;
   logic [9:0]  stacks_ff;
   logic        inverted_ff;

   // never holds requests off
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff   <= 16'd256;
         slices_ff   <= 10'd16;
         stacks_ff   <= 10'd16;
         inverted_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_addr_type'(csr_index))
            CSR_RADIUS:   radius_ff   <= csr_data;
            CSR_SLICES:   slices_ff   <= csr_data[9:0];
            CSR_STACKS:   stacks_ff   <= csr_data[9:0];
            CSR_INVERTED: inverted_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // ----------------------------------------------------- request decode
   // Status and list index are settled on entry and ride along with the item.
   logic [10:0]     t_m1;
   logic [19:0]     ring_cnt;
   logic [NV_W-1:0] nverts;
   logic [19:0]     ring_base;
   meta_type        meta_new;

   always_comb begin
      t_m1      = {1'b0, stacks_ff} - 11'd1;
      ring_cnt  = slices_ff * t_m1[9:0];
      nverts    = {1'b0, ring_cnt} + NV_W'(2);
      ring_base = slices_ff * (req_stack_index - 10'd1);

      meta_new.status = STAT_OK;
      meta_new.vnum   = 16'd0;
      meta_new.kind   = KIND_RING;
      if (slices_ff == 10'd0 || stacks_ff < 10'd2) begin
         meta_new.status = STAT_EMPTY;
      end else if (nverts > NV_W'(MAX_VERTICES)) begin
         meta_new.status = STAT_TOO_MANY;
      end else if (req_stack_index > stacks_ff ||
                   (req_stack_index != 10'd0 && req_stack_index != stacks_ff &&
                    req_slice_index >= slices_ff)) begin
         meta_new.status = STAT_RANGE;
      end else if (req_stack_index == 10'd0) begin
         meta_new.kind = KIND_TOP;
      end else if (req_stack_index == stacks_ff) begin
         meta_new.kind = KIND_BOTTOM;
         meta_new.vnum = 16'(nverts - NV_W'(1));
      end else begin
         meta_new.vnum = 16'(ring_base + 20'(req_slice_index) + 20'd1);
      end
   end

   // ----------------------------------------------------- valid / meta line
   logic     vld_ff  [ST_RAD+1];
   logic     vld_in  [ST_RAD+1];
   meta_type meta_ff [ST_RAD+1];
   meta_type meta_in [ST_RAD+1];

   always_comb begin
      vld_in[0]  = start & ~busy;
      meta_in[0] = meta_new;
      for (int k = 1; k <= ST_RAD; k++) begin
         vld_in[k]  = vld_ff[k-1];
         meta_in[k] = meta_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= ST_RAD; k++) begin
         meta_ff[k] <= meta_in[k];
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_in[k];
         end
      end
   end

   // ----------------------------------------------------- phase dividers
   // Lane 0: slice * 2^32 / S. Lane 1: stack * 2^32 / T, halved afterwards.
   // Restoring division, remainder kept below the divisor.
   logic [9:0]  rem_ff [2][DIV_STG+1];
   logic [9:0]  rem_in [2][DIV_STG+1];
   logic [31:0] quo_ff [2][DIV_STG+1];
   logic [31:0] quo_in [2][DIV_STG+1];

   always_comb begin : div_comb
      logic [10:0] r2;
      logic [9:0]  r;
      logic [31:0] q;
      logic [9:0]  den;
      rem_in[0][0] = req_slice_index;
      rem_in[1][0] = req_stack_index;
      quo_in[0][0] = 32'd0;
      quo_in[1][0] = 32'd0;
      for (int l = 0; l < 2; l++) begin
         den = (l == 0) ? slices_ff : stacks_ff;
         for (int d = 1; d <= DIV_STG; d++) begin
            r = rem_ff[l][d-1];
            q = quo_ff[l][d-1];
            for (int j = 0; j < DIV_PER; j++) begin
               r2 = {r, 1'b0};
               if (r2 >= {1'b0, den}) begin
                  r = 10'(r2 - {1'b0, den});
                  q = {q[30:0], 1'b1};
               end else begin
                  r = r2[9:0];
                  q = {q[30:0], 1'b0};
               end
            end
            rem_in[l][d] = r;
            quo_in[l][d] = q;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 2; l++) begin
         for (int d = 0; d <= DIV_STG; d++) begin
            rem_ff[l][d] <= rem_in[l][d];
            quo_ff[l][d] <= quo_in[l][d];
         end
      end
   end

   // ----------------------------------------------------- CORDIC lanes
   // Index 0 holds the angle stage: quadrant split and scaling to Q30 radians.
   logic signed [CW-1:0] cx_ff   [2][CORD_STG+1];
   logic signed [CW-1:0] cx_in   [2][CORD_STG+1];
   logic signed [CW-1:0] cy_ff   [2][CORD_STG+1];
   logic signed [CW-1:0] cy_in   [2][CORD_STG+1];
   logic signed [CW-1:0] cz_ff   [2][CORD_STG+1];
   logic signed [CW-1:0] cz_in   [2][CORD_STG+1];
   logic [1:0]           quad_ff [2][CORD_STG+1];
   logic [1:0]           quad_in [2][CORD_STG+1];

   always_comb begin : cordic_comb
      logic [31:0]          phase;
      logic [60:0]          zprod;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      int                   k;
      for (int l = 0; l < 2; l++) begin
         phase = (l == 0) ? quo_ff[0][DIV_STG] : {1'b0, quo_ff[1][DIV_STG][31:1]};
         zprod = phase[29:0] * HALF_PI_Q30;
         quad_in[l][0] = phase[31:30];
         cx_in[l][0]   = CORDIC_GAIN;
         cy_in[l][0]   = '0;
         cz_in[l][0]   = $signed({3'b000, zprod[60:30]});
         for (int c = 1; c <= CORD_STG; c++) begin
            x = cx_ff[l][c-1];
            y = cy_ff[l][c-1];
            z = cz_ff[l][c-1];
            for (int j = 0; j < CORD_PER; j++) begin
               k  = (c - 1) * CORD_PER + j;
               dx = y >>> k;
               dy = x >>> k;
               if (!z[CW-1]) begin
                  x = x - dx;
                  y = y + dy;
                  z = z - ATAN_Q30[k];
               end else begin
                  x = x + dx;
                  y = y - dy;
                  z = z + ATAN_Q30[k];
               end
            end
            cx_in[l][c]   = x;
            cy_in[l][c]   = y;
            cz_in[l][c]   = z;
            quad_in[l][c] = quad_ff[l][c-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 2; l++) begin
         for (int c = 0; c <= CORD_STG; c++) begin
            cx_ff[l][c]   <= cx_in[l][c];
            cy_ff[l][c]   <= cy_in[l][c];
            cz_ff[l][c]   <= cz_in[l][c];
            quad_ff[l][c] <= quad_in[l][c];
         end
      end
   end

   // ----------------------------------------------------- quadrant and products
   logic signed [63:0] prod_ff [2];
   logic signed [63:0] prod_in [2];
   logic signed [31:0] cb_ff;
   logic signed [31:0] cb_in;

   always_comb begin : prod_comb
      logic signed [CW-1:0] cs [2];
      logic signed [CW-1:0] sn [2];
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      for (int l = 0; l < 2; l++) begin
         x = cx_ff[l][CORD_STG];
         y = cy_ff[l][CORD_STG];
         case (quad_ff[l][CORD_STG])
            2'd0:    begin cs[l] = x;  sn[l] = y;  end
            2'd1:    begin cs[l] = -y; sn[l] = x;  end
            2'd2:    begin cs[l] = -x; sn[l] = -y; end
            default: begin cs[l] = y;  sn[l] = -x; end
         endcase
      end
      // lane 0 is the slice angle, lane 1 the stack angle
      prod_in[0] = $signed(cs[0][31:0]) * $signed(sn[1][31:0]);
      prod_in[1] = $signed(sn[0][31:0]) * $signed(sn[1][31:0]);
      cb_in      = $signed(cs[1][31:0]);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      cb_ff   <= cb_in;
   end

   // ----------------------------------------------------- unit vector
   logic signed [31:0] unit_ff [3];
   logic signed [31:0] unit_in [3];

   always_comb begin
      case (meta_ff[ST_MUL].kind)
         KIND_TOP: begin
            unit_in[0] = '0;
            unit_in[1] = Q30_ONE;
            unit_in[2] = '0;
         end
         KIND_BOTTOM: begin
            unit_in[0] = '0;
            unit_in[1] = -Q30_ONE;
            unit_in[2] = '0;
         end
         default: begin
            unit_in[0] = 32'(round_shift(prod_ff[0], 30));
            unit_in[1] = cb_ff;
            unit_in[2] = 32'(round_shift(prod_ff[1], 30));
         end
      endcase
   end

   always_ff @(posedge clock) begin
      unit_ff <= unit_in;
   end

   // ----------------------------------------------------- radius scale, normal
   logic signed [48:0] pm_ff [3];
   logic signed [48:0] pm_in [3];
   logic signed [31:0] nr_ff [3];
   logic signed [31:0] nr_in [3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         pm_in[a] = unit_ff[a] * $signed({1'b0, radius_ff});
         nr_in[a] = 32'(round_shift(64'(unit_ff[a]), NSH));
      end
   end

   always_ff @(posedge clock) begin
      pm_ff <= pm_in;
      nr_ff <= nr_in;
   end

   // ----------------------------------------------------- clamp, invert, output
   logic               out_vld_ff;
   logic               out_vld_in;
   logic signed [16:0] pos_ff  [3];
   logic signed [16:0] pos_in  [3];
   logic signed [15:0] norm_ff [3];
   logic signed [15:0] norm_in [3];
   logic [15:0]        vnum_ff;
   logic [15:0]        vnum_in;
   logic [1:0]         stat_ff;
   logic [1:0]         stat_in;

   always_comb begin : out_comb
      logic signed [63:0] p;
      logic signed [31:0] n;
      logic               err;
      err        = (meta_ff[ST_RAD].status != STAT_OK);
      out_vld_in = vld_ff[ST_RAD];
      vnum_in    = err ? 16'd0 : meta_ff[ST_RAD].vnum;
      stat_in    = meta_ff[ST_RAD].status;
      for (int a = 0; a < 3; a++) begin
         p = round_shift(64'(pm_ff[a]), 30);
         if (p > 64'(POS_LIMIT)) begin
            p = 64'(POS_LIMIT);
         end else if (p < -64'(POS_LIMIT)) begin
            p = -64'(POS_LIMIT);
         end
         n = nr_ff[a];
         if (n > NORM_LIM) begin
            n = NORM_LIM;
         end else if (n < -NORM_LIM) begin
            n = -NORM_LIM;
         end
         if (inverted_ff) begin
            p = -p;
            n = -n;
         end
         pos_in[a]  = err ? 17'sd0 : 17'(p);
         norm_in[a] = err ? 16'sd0 : 16'(n);
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      norm_ff <= norm_in;
      vnum_ff <= vnum_in;
      stat_ff <= stat_in;
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_pos_x         = pos_ff[0];
   assign rsp_pos_y         = pos_ff[1];
   assign rsp_pos_z         = pos_ff[2];
   assign rsp_norm_x        = norm_ff[0];
   assign rsp_norm_y        = norm_ff[1];
   assign rsp_norm_z        = norm_ff[2];
   assign rsp_vertex_number = vnum_ff;
   assign rsp_status        = stat_ff;

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sphere vertex generator. It drives requests
// with random gaps under a series of register settings, predicts every
// vertex with its own CORDIC model and compares each response strobe
// against the oldest pending prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
   import svg_pkg::*;

   localparam int LATENCY     = 28;
   localparam int SETTLE      = LATENCY + 12;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      logic signed [16:0] pos_x, pos_y, pos_z;
      logic signed [15:0] norm_x, norm_y, norm_z;
      logic [15:0]        vnum;
      status_type         status;
   } vertex_type;

   // Vertex predictor plus the queue of predicted vertices
   class vertex_scoreboard;
      int unsigned radius   = 256;
      int unsigned slices   = 16;
      int unsigned stacks   = 16;
      bit          inverted = 1'b0;
      vertex_type  pending[$];
      int          errors   = 0;

      function void write_reg(csr_addr_type idx, logic [15:0] val);
         case (idx)
            CSR_RADIUS:   radius   = 32'(val);
            CSR_SLICES:   slices   = 32'(val[9:0]);
            CSR_STACKS:   stacks   = 32'(val[9:0]);
            CSR_INVERTED: inverted = val[0];
            default: ;
         endcase
      endfunction

      function longint rnd_shift(longint v, int k);
         longint unsigned mag;
         longint unsigned r;
         mag = (v < 0) ? longint'(-v) : longint'(v);
         r   = (mag + (64'd1 << (k - 1))) >> k;
         return (v < 0) ? -longint'(r) : longint'(r);
      endfunction

      function longint clamp(longint v, longint lim);
         if (v > lim) return lim;
         if (v < -lim) return -lim;
         return v;
      endfunction

      // cosine and sine in Q30 of a 32-bit fraction of a turn
      function void turn_cos_sin(logic [31:0] phase, output longint c, output longint s);
         longint x, y, z, dx, dy;
         longint unsigned rest;
         rest = 64'(phase[29:0]);
         z = longint'((rest * longint'(HALF_PI_Q30)) >> 30);
         x = longint'(CORDIC_GAIN);
         y = 0;
         for (int k = 0; k < CORDIC_STEPS; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
               x = x - dx; y = y + dy; z = z - longint'(ATAN_Q30[k]);
            end else begin
               x = x + dx; y = y - dy; z = z + longint'(ATAN_Q30[k]);
            end
         end
         case (phase[31:30])
            2'd0:    begin c = x;  s = y;  end
            2'd1:    begin c = -y; s = x;  end
            2'd2:    begin c = -x; s = -y; end
            default: begin c = y;  s = -x; end
         endcase
      endfunction

      function vertex_type predict(int unsigned st, int unsigned sl);
         vertex_type  v;
         longint      unit[3];
         longint      nrm[3], pos[3];
         longint      ca, sa, cb, sb;
         int unsigned nverts;
         logic [31:0] ph_a, ph_b;
         unit = '{0, 0, 0};
         v.status = STAT_OK;
         v.vnum = '0;
         nverts = slices * (stacks - 1) + 2;
         if (slices == 0 || stacks < 2) v.status = STAT_EMPTY;
         else if (nverts > MAX_VERTICES_DEF) v.status = STAT_TOO_MANY;
         else if (st > stacks || (st != 0 && st != stacks && sl >= slices))
            v.status = STAT_RANGE;
         else if (st == 0) begin
            unit[1] = 64'sd1 << 30;
         end else if (st == stacks) begin
            unit[1] = -(64'sd1 << 30);
            v.vnum = 16'(nverts - 1);
         end else begin
            ph_a = 32'((longint'(sl) << 32) / slices);
            ph_b = 32'((longint'(st) << 31) / stacks);
            turn_cos_sin(ph_a, ca, sa);
            turn_cos_sin(ph_b, cb, sb);
            unit[0] = rnd_shift(ca * sb, 30);
            unit[1] = cb;
            unit[2] = rnd_shift(sa * sb, 30);
            v.vnum = 16'(1 + (st - 1) * slices + sl);
         end
         for (int a = 0; a < 3; a++) begin
            if (v.status != STAT_OK) begin
               nrm[a] = 0; pos[a] = 0;
            end else begin
               nrm[a] = clamp(rnd_shift(unit[a], 30 - UNIT_FRAC_BITS_DEF),
                              64'sd1 << UNIT_FRAC_BITS_DEF);
               pos[a] = clamp(rnd_shift(unit[a] * longint'(radius), 30), 65535);
               if (inverted) begin
                  nrm[a] = -nrm[a]; pos[a] = -pos[a];
               end
            end
         end
         v.pos_x = 17'(pos[0]);  v.pos_y = 17'(pos[1]);  v.pos_z = 17'(pos[2]);
         v.norm_x = 16'(nrm[0]); v.norm_y = 16'(nrm[1]); v.norm_z = 16'(nrm[2]);
         return v;
      endfunction

      function void note(logic [9:0] st, logic [9:0] sl);
         pending.push_back(predict(st, sl));
      endfunction

      function void compare(string name, longint e, longint g);
         if (e != g) begin
            errors++;
            if (errors <= 40)
               $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, g);
         end
      endfunction

      function void check(vertex_type got);
         vertex_type e;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 40)
               $display("%0t: response with no pending request, expected none, actual vnum %0d",
                        $time, got.vnum);
            return;
         end
         e = pending.pop_front();
         compare("pos_x",  e.pos_x,  got.pos_x);
         compare("pos_y",  e.pos_y,  got.pos_y);
         compare("pos_z",  e.pos_z,  got.pos_z);
         compare("norm_x", e.norm_x, got.norm_x);
         compare("norm_y", e.norm_y, got.norm_y);
         compare("norm_z", e.norm_z, got.norm_z);
         compare("vertex_number", e.vnum, got.vnum);
         compare("status", e.status, got.status);
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [9:0]         req_stack_index = '0;
   logic [9:0]         req_slice_index = '0;
   logic               rsp_valid;
   logic signed [16:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [15:0] rsp_norm_x, rsp_norm_y, rsp_norm_z;
   logic [15:0]        rsp_vertex_number;
   logic [1:0]         rsp_status;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   csr_addr_type       csr_index = CSR_RADIUS;
   logic [15:0]        csr_data  = '0;

   vertex_scoreboard   sb = new();
   int                 cycles = 0;
   // current mesh shape, mirrored here to steer stimulus
   int unsigned        cur_slices = 16;
   int unsigned        cur_stacks = 16;
   bit                 no_gaps = 1'b0;

   sphere_vertex_generator_top DUT (
      .clock, .reset, .start, .busy, .req_stack_index, .req_slice_index,
      .rsp_valid, .rsp_pos_x, .rsp_pos_y, .rsp_pos_z,
      .rsp_norm_x, .rsp_norm_y, .rsp_norm_z, .rsp_vertex_number, .rsp_status,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Cycle watchdog: a hung pipeline ends the run here
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Monitors sample pre-edge values, so the drivers' nonblocking updates
   // at the same edge cannot race them.
   always @(posedge clock) begin
      if (!reset && start && !busy) sb.note(req_stack_index, req_slice_index);
      if (!reset && csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
   end

   always @(posedge clock) begin
      vertex_type got;
      if (!reset && rsp_valid) begin
         got.pos_x  = rsp_pos_x;  got.pos_y  = rsp_pos_y;  got.pos_z  = rsp_pos_z;
         got.norm_x = rsp_norm_x; got.norm_y = rsp_norm_y; got.norm_z = rsp_norm_z;
         got.vnum   = rsp_vertex_number;
         got.status = status_type'(rsp_status);
         sb.check(got);
      end
   end

   // mostly short gaps, now and then a long one
   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   // Hold start high across back-to-back requests; drop it only for a gap
   task automatic send_vertex(logic [9:0] st, logic [9:0] sl);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_stack_index <= st;
      req_slice_index <= sl;
      do @(posedge clock); while (busy);
   endtask

   // Drop start, then wait out every pending vertex plus the pipeline depth
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Hold valid across consecutive writes; the caller drops it after the last
   task automatic write_csr(csr_addr_type idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_mesh(logic [15:0] rad, int unsigned s, int unsigned t, bit inv);
      drain();
      write_csr(CSR_RADIUS, rad);
      write_csr(CSR_SLICES, 16'(s));
      write_csr(CSR_STACKS, 16'(t));
      write_csr(CSR_INVERTED, 16'(inv));
      csr_valid <= 1'b0;
      @(posedge clock);
      cur_slices = s;
      cur_stacks = t;
   endtask

   // Mostly in-range vertices of the current mesh, the rest raw noise
   task automatic random_vertices(int n);
      logic [9:0] st, sl;
      for (int k = 0; k < n; k++) begin
         if ((k % 50) == 0) no_gaps = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 99) < 85 && cur_slices > 0) begin
            st = 10'($urandom_range(0, cur_stacks));
            sl = 10'($urandom_range(0, cur_slices - 1));
         end else begin
            st = 10'($urandom);
            sl = 10'($urandom);
         end
         send_vertex(st, sl);
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: poles with odd slices, range errors, each quadrant
      send_vertex(10'd0, 10'd1023);
      send_vertex(10'd16, 10'd5);
      send_vertex(10'd17, 10'd0);
      send_vertex(10'd1023, 10'd1023);
      send_vertex(10'd3, 10'd16);
      send_vertex(10'd1, 10'd0);
      send_vertex(10'd15, 10'd15);
      send_vertex(10'd8, 10'd0);
      send_vertex(10'd8, 10'd4);
      send_vertex(10'd8, 10'd8);
      send_vertex(10'd8, 10'd12);
      // empty mesh by slices and by stacks, too many vertices
      set_mesh(16'd256, 0, 16, 1'b0);
      send_vertex(10'd0, 10'd0);
      send_vertex(10'd5, 10'd3);
      set_mesh(16'd256, 8, 1, 1'b0);
      send_vertex(10'd0, 10'd0);
      set_mesh(16'd256, 8, 0, 1'b0);
      send_vertex(10'd0, 10'd0);
      set_mesh(16'd256, 1023, 1023, 1'b0);
      send_vertex(10'd1, 10'd1);
      send_vertex(10'd1023, 10'd0);
      // smallest mesh, full radius inverted, then zero radius
      set_mesh(16'hFFFF, 1, 2, 1'b1);
      send_vertex(10'd0, 10'd0);
      send_vertex(10'd1, 10'd0);
      send_vertex(10'd2, 10'd0);
      send_vertex(10'd1, 10'd1);
      set_mesh(16'd0, 4, 4, 1'b0);
      send_vertex(10'd2, 10'd1);

      // Random phases
      set_mesh(16'd256, 16, 16, 1'b0);
      random_vertices(90);
      set_mesh(16'hFFFF, 64, 1023, 1'b1);
      random_vertices(110);
      set_mesh(16'h8000 | 16'($urandom), 1023, 8, 1'b0);
      random_vertices(110);
      set_mesh(16'd0, 3, 2, 1'b1);
      random_vertices(50);
      for (int p = 0; p < 5; p++) begin
         set_mesh(16'($urandom), $urandom_range(1, 40), $urandom_range(2, 40),
                  1'($urandom));
         random_vertices(60);
      end
      set_mesh(16'($urandom), 1023, 1023, 1'b1);
      random_vertices(15);
      set_mesh(16'($urandom), 0, 12, 1'b0);
      random_vertices(15);

      drain();
      sb.errors += sb.pending.size();
      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
